// ===== rtl/rhp_pkg.sv =====
// Shared types and constants for the RGB histogram pass-through unit.
package rhp_pkg;

  localparam int PIX_W    = 24;
  localparam int CNT_W    = 32;
  localparam int SLOT_W   = 5;
  localparam int M_DATA_W = 64;
  localparam int M_USER_W = 2;

  // result kind, carried in m_tuser[0]
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // bank order follows the dump slot order
  localparam logic [1:0] BANK_HI  = 2'd0;
  localparam logic [1:0] BANK_LO  = 2'd1;
  localparam logic [1:0] BANK_MID = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DUMP_RD,
    ST_DUMP_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic upd_wr;
    logic dump_rd;
    logic dump_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pix_fs;
    logic dump_last;
  } ctrl_stat_t;

endpackage

// ===== rtl/rhp_bank.sv =====
// One channel's bin counters: single-port-per-direction store with valid bits.
module rhp_bank #(
  parameter int DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  logic [rhp_pkg::CNT_W-1:0]       wr_data,
  input  logic                            clr_en,
  input  logic [$clog2(DEPTH)-1:0]        clr_addr,
  output logic [rhp_pkg::CNT_W-1:0]       rd_data,
  output logic                            rd_valid
);

  logic [rhp_pkg::CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= vld[rd_addr];
    end
  end

  // an entry without its valid bit reads with rd_valid low; the datapath then treats it as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        vld[clr_addr] <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rhp_ctrl.sv =====
// Controller: sequences pixel update and histogram dump.
module rhp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  rhp_pkg::ctrl_stat_t stat,
  output rhp_pkg::ctrl_cmd_t  cmd
);

  rhp_pkg::state_t state;
  rhp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rhp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rhp_pkg::ST_IDLE: begin
        if (s_tvalid && stat.out_free) begin
          state_next = rhp_pkg::ST_UPDATE;
        end
      end
      rhp_pkg::ST_UPDATE: begin
        state_next = stat.pix_fs ? rhp_pkg::ST_DUMP_RD : rhp_pkg::ST_IDLE;
      end
      rhp_pkg::ST_DUMP_RD: begin
        state_next = rhp_pkg::ST_DUMP_EMIT;
      end
      rhp_pkg::ST_DUMP_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.dump_last ? rhp_pkg::ST_IDLE : rhp_pkg::ST_DUMP_RD;
        end
      end
      default: state_next = rhp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    unique case (state)
      rhp_pkg::ST_IDLE: begin
        s_tready   = stat.out_free;
        cmd.accept = stat.out_free && s_tvalid;
      end
      rhp_pkg::ST_UPDATE: begin
        cmd.upd_wr = 1'b1;
      end
      rhp_pkg::ST_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
      end
      rhp_pkg::ST_DUMP_EMIT: begin
        cmd.dump_emit = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/rhp_dpath.sv =====
// Datapath: bin mapping, counter banks, dump counters and output register.
module rhp_dpath #(
  parameter int NUM_BINS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rhp_pkg::PIX_W-1:0]     s_tdata,
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  input  rhp_pkg::ctrl_cmd_t            cmd,
  output rhp_pkg::ctrl_stat_t           stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rhp_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [rhp_pkg::M_USER_W-1:0]  m_tuser,
  output logic                          m_tlast
);

  localparam int BW = $clog2(NUM_BINS);
  localparam int SW = $clog2(3 * NUM_BINS);
  localparam int PW = BW + 9;
  localparam int PAD_W = rhp_pkg::M_DATA_W - rhp_pkg::PIX_W - 1 - rhp_pkg::SLOT_W
                         - rhp_pkg::CNT_W;

  // bin = (v * NUM_BINS) >> 8, always below NUM_BINS
  function automatic logic [BW-1:0] bin_of(input logic [7:0] v);
    logic [PW-1:0] prod;
    prod = PW'(v) * PW'(NUM_BINS);
    return prod[8 +: BW];
  endfunction

  logic [BW-1:0]             in_bin  [3];
  logic [BW-1:0]             pix_bin [3];
  logic                      pix_fs;
  logic [1:0]                dump_bank;
  logic [BW-1:0]             dump_bin;
  logic [SW-1:0]             slot_cnt;
  logic [SW+4:0]             slot_ext;
  logic [rhp_pkg::CNT_W-1:0] bank_data [3];
  logic                      bank_valid [3];
  logic [rhp_pkg::CNT_W-1:0] cnt_sel;

  assign in_bin[rhp_pkg::BANK_HI]  = bin_of(s_tdata[23:16]);
  assign in_bin[rhp_pkg::BANK_LO]  = bin_of(s_tdata[7:0]);
  assign in_bin[rhp_pkg::BANK_MID] = bin_of(s_tdata[15:8]);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_bin <= in_bin;
      pix_fs  <= s_tuser;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_bank
    logic                      rd_en;
    logic [BW-1:0]             rd_addr;
    logic [rhp_pkg::CNT_W-1:0] wr_data;
    logic                      clr_en;

    assign rd_en   = cmd.accept || (cmd.dump_rd && dump_bank == 2'(g));
    assign rd_addr = cmd.accept ? in_bin[g] : dump_bin;
    assign wr_data = (bank_valid[g] ? bank_data[g] : '0) + rhp_pkg::CNT_W'(1);
    assign clr_en  = cmd.dump_emit && dump_bank == 2'(g);

    rhp_bank #(
      .DEPTH (NUM_BINS)
    ) u_bank (
      .clk      (clk),
      .rst      (rst),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .wr_en    (cmd.upd_wr),
      .wr_addr  (pix_bin[g]),
      .wr_data  (wr_data),
      .clr_en   (clr_en),
      .clr_addr (dump_bin),
      .rd_data  (bank_data[g]),
      .rd_valid (bank_valid[g])
    );
  end

  // dump walk: bank by bank, bin by bin, slot alongside
  always_ff @(posedge clk) begin
    if (cmd.upd_wr) begin
      dump_bank <= rhp_pkg::BANK_HI;
      dump_bin  <= '0;
      slot_cnt  <= '0;
    end else if (cmd.dump_emit) begin
      slot_cnt <= slot_cnt + SW'(1);
      if (dump_bin == BW'(NUM_BINS - 1)) begin
        dump_bin  <= '0;
        dump_bank <= dump_bank + 2'd1;
      end else begin
        dump_bin <= dump_bin + BW'(1);
      end
    end
  end

  always_comb begin
    case (dump_bank)
      rhp_pkg::BANK_HI:  cnt_sel = bank_valid[0] ? bank_data[0] : '0;
      rhp_pkg::BANK_LO:  cnt_sel = bank_valid[1] ? bank_data[1] : '0;
      rhp_pkg::BANK_MID: cnt_sel = bank_valid[2] ? bank_data[2] : '0;
      default:           cnt_sel = '0;
    endcase
  end

  // slot field keeps the low five bits of the slot number
  assign slot_ext = {5'b0, slot_cnt};

  assign stat.out_free  = !m_tvalid || m_tready;
  assign stat.pix_fs    = pix_fs;
  assign stat.dump_last = dump_bank == rhp_pkg::BANK_MID && dump_bin == BW'(NUM_BINS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.accept || cmd.dump_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      m_tdata <= {PAD_W'(0), rhp_pkg::CNT_W'(0), rhp_pkg::SLOT_W'(0), s_tlast, s_tdata};
      m_tuser <= {s_tuser, rhp_pkg::KIND_PIXEL};
      m_tlast <= !s_tuser;
    end else if (cmd.dump_emit) begin
      m_tdata <= {PAD_W'(0), cnt_sel, slot_ext[4:0], 1'b0, rhp_pkg::PIX_W'(0)};
      m_tuser <= {1'b0, rhp_pkg::KIND_COUNT};
      m_tlast <= stat.dump_last;
    end
  end

  a_pixel_first: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> m_tvalid && m_tuser[0] == rhp_pkg::KIND_PIXEL)
    else $error("pixel request not presented after acceptance");

  a_count_word: assert property (@(posedge clk) disable iff (rst)
    cmd.dump_emit |=> m_tvalid && m_tuser[0] == rhp_pkg::KIND_COUNT
                      && m_tlast == $past(stat.dump_last))
    else $error("count word or its last flag wrong");

  a_dump_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_wr |=> dump_bank == rhp_pkg::BANK_HI && dump_bin == '0 && slot_cnt == '0)
    else $error("dump walk not rewound after update");

  a_bank_range: assert property (@(posedge clk) disable iff (rst)
    cmd.dump_emit |-> dump_bank == rhp_pkg::BANK_HI || dump_bank == rhp_pkg::BANK_LO
                      || dump_bank == rhp_pkg::BANK_MID)
    else $error("dump ran past the last bank");

endmodule

// ===== rtl/rgb_histogram_passthrough_unit.sv =====
// Top level: per-channel colour histogram with pixel pass-through.
// The passed pixel is registered and shows on the master side the cycle after it is taken.
// A pixel's counters are read as it is taken and written back in the update state, before
// the next is taken. A start-of-frame pixel then dumps all 3*NUM_BINS counts as output allows;
// each bank has one read and one write port, so the dump reads one counter at a time.
// Reset: synchronous; clears the controller and the counters' valid bits, so all counts read 0.
module rgb_histogram_passthrough_unit #(
  parameter int NUM_BINS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rhp_pkg::PIX_W-1:0]     s_tdata,   // [23:0] pixel
  input  logic                          s_tuser,   // [0] frame_start
  input  logic                          s_tlast,   // line_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [23:0] pixel_out, [24] line_end_out, [29:25] slot, [61:30] count, [63:62] zero
  output logic [rhp_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [rhp_pkg::M_USER_W-1:0]  m_tuser,   // [0] kind, [1] frame_start_out
  output logic                          m_tlast    // last_of_run
);

  rhp_pkg::ctrl_cmd_t  cmd;
  rhp_pkg::ctrl_stat_t stat;

  rhp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rhp_dpath #(
    .NUM_BINS (NUM_BINS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
